// File: rtl/chunk_table_order_validator_core_macros.svh
// Assertion macros shared by the validator RTL.
`ifndef CHUNK_TABLE_ORDER_VALIDATOR_CORE_MACROS_SVH
`define CHUNK_TABLE_ORDER_VALIDATOR_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define CTOV_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define CTOV_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define CTOV_ASSERT_IMP(name, clk, rst_n, ante, cons, msg)
`define CTOV_ASSERT_NXT(name, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: rtl/ctov_pkg.sv
`default_nettype none
package ctov_pkg;

	localparam int MAX_CHUNKS = 1024;

	localparam int IDX_W = 32;
	localparam int SIZE_W = 64;
	localparam int CNT_W = 11;
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
	localparam logic [IDX_W-1:0] NO_CHUNK = 32'hFFFF_FFFF;
	localparam logic [IDX_W-1:0] MAX_CHUNKS_IDX = IDX_W'(MAX_CHUNKS);

	localparam int BM_COLS = 32;
	localparam int BM_COL_W = 5;
	localparam int BM_ROWS = (MAX_CHUNKS + BM_COLS - 1) / BM_COLS;
	localparam int BM_ROW_AW = (BM_ROWS > 1) ? $clog2(BM_ROWS) : 1;

	localparam int CFG_AW = 5;
	localparam int CFG_DW = 64;

	typedef enum logic [1:0] {
		REQ_CHUNK  = 2'd0,
		REQ_APPLY  = 2'd1,
		REQ_FINISH = 2'd2
	} req_type_t;

	typedef enum logic [2:0] {
		ERR_OK       = 3'd0,
		ERR_INDEX    = 3'd1,
		ERR_EMPTY    = 3'd2,
		ERR_BOUNDS   = 3'd3,
		ERR_OVERLAP  = 3'd4,
		ERR_MISSING  = 3'd5,
		ERR_DUP      = 3'd6,
		ERR_SEQ      = 3'd7
	} err_code_t;

	typedef enum logic [1:0] {
		REG_CHUNK_COUNT   = 2'd0,
		REG_PAYLOAD_START = 2'd1,
		REG_FILE_SIZE     = 2'd2,
		REG_MAX_CHUNK     = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic                 en;
		logic                 clr;
		logic [BM_ROW_AW-1:0] row;
		logic [BM_COLS-1:0]   data;
	} bm_wr_t;

endpackage
`default_nettype wire

// File: rtl/ctov_if.sv
`default_nettype none
interface ctov_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [31:0] entry_index;
	logic [63:0] chunk_size;
	logic [63:0] chunk_offset;

	modport source (output valid, output req_type, output entry_index,
		output chunk_size, output chunk_offset, input ready);
	modport sink (input valid, input req_type, input entry_index,
		input chunk_size, input chunk_offset, output ready);
endinterface

interface ctov_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  error_code;
	logic [31:0] error_chunk;
	logic        error_chunk_valid;
	logic        finished;

	modport source (output valid, output error_code, output error_chunk,
		output error_chunk_valid, output finished, input ready);
	modport sink (input valid, input error_code, input error_chunk,
		input error_chunk_valid, input finished, output ready);
endinterface
`default_nettype wire

// File: rtl/chunk_table_order_validator_core.sv
// An accepted word is held in the stage registers until its result is written to the result register.
// Throughput: one word per cycle unless out_ch.ready stalls; checks and bitmap row update sit in one stage.
// The seen-bitmap is a 32-bit-row memory read as the word is accepted and written back.
// Reset (arst_n low, asynchronous) clears counters, errors and the row valid bits, and
// returns the configuration registers to their defaults.
// A finish clears the bitmap at once through the row valid bits; there is no clearing pass.
`default_nettype none
`include "chunk_table_order_validator_core_macros.svh"
module chunk_table_order_validator_core (
	input  wire                          clk,
	input  wire                          arst_n,
	ctov_in_if.sink                      in_ch,
	ctov_out_if.source                   out_ch,
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire  [ctov_pkg::CFG_AW-1:0]  paddr,
	input  wire  [ctov_pkg::CFG_DW-1:0]  pwdata,
	output logic [ctov_pkg::CFG_DW-1:0]  prdata,
	output logic                         pready
);
	import ctov_pkg::*;

	logic [CNT_W-1:0]  chunk_count_q;
	logic [SIZE_W-1:0] payload_start_q;
	logic [SIZE_W-1:0] file_size_q;
	logic [SIZE_W-1:0] max_chunk_q;
	logic              cfg_we;
	cfg_reg_t          cfg_sel;

	logic [CNT_W-1:0]  chunks_seen_q, nxt_seen;
	logic [CNT_W-1:0]  applies_seen_q, nxt_apps;
	logic [SIZE_W-1:0] prev_end_q, nxt_prev;
	err_code_t         first_error_q, nxt_err;
	logic [IDX_W-1:0]  first_chunk_q, nxt_chunk;
	logic              first_has_q, nxt_has;

	logic              valid_s1;
	logic [1:0]        req_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic [SIZE_W-1:0] size_s1;
	logic [SIZE_W-1:0] off_s1;

	logic              out_valid_q;
	err_code_t         out_code_q;
	logic [IDX_W-1:0]  out_chunk_q;
	logic              out_has_q;
	logic              out_fin_q;

	logic              s1_go;
	logic              in_ready;
	logic              in_acc;
	logic              fin;
	logic              bm_set;
	logic              cnt_full;
	logic [SIZE_W:0]   end_sum;
	logic              bounds_bad;
	logic              apply_missing;
	logic              hit;
	logic [BM_COLS-1:0] bm_rd_data;
	bm_wr_t            bm_wr;

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;
	assign cfg_sel = cfg_reg_t'(paddr[CFG_AW-1:CFG_AW-2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_count_q <= '0;
			payload_start_q <= '0;
			file_size_q <= '0;
			max_chunk_q <= '1;
		end else if (cfg_we) begin
			unique case (cfg_sel)
				REG_CHUNK_COUNT: chunk_count_q <= pwdata[CNT_W-1:0];
				REG_PAYLOAD_START: payload_start_q <= pwdata;
				REG_FILE_SIZE: file_size_q <= pwdata;
				REG_MAX_CHUNK: max_chunk_q <= pwdata;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_sel)
			REG_CHUNK_COUNT: prdata = CFG_DW'(chunk_count_q);
			REG_PAYLOAD_START: prdata = payload_start_q;
			REG_FILE_SIZE: prdata = file_size_q;
			REG_MAX_CHUNK: prdata = max_chunk_q;
		endcase
	end

	// Handshake.
	assign s1_go = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ready = !valid_s1 || s1_go;
	assign in_acc = in_ch.valid && in_ready;
	assign in_ch.ready = in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			req_s1 <= in_ch.req_type;
			idx_s1 <= in_ch.entry_index;
			size_s1 <= in_ch.chunk_size;
			off_s1 <= in_ch.chunk_offset;
		end
	end

	ctov_bitmap u_bitmap (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (in_acc),
		.rd_row  (in_ch.entry_index[BM_COL_W +: BM_ROW_AW]),
		.wr      (bm_wr),
		.rd_data (bm_rd_data)
	);

	// Checks for the word in the stage.
	assign cnt_full = chunks_seen_q >= chunk_count_q;
	assign end_sum = {1'b0, off_s1} + {1'b0, size_s1};
	assign bounds_bad = (size_s1 > max_chunk_q) || (off_s1 < payload_start_q) ||
		(end_sum > {1'b0, file_size_q});
	assign apply_missing = (idx_s1 >= IDX_W'(chunk_count_q)) || (idx_s1 >= MAX_CHUNKS_IDX);
	assign hit = bm_rd_data[idx_s1[BM_COL_W-1:0]];

	always_comb begin
		nxt_err = first_error_q;
		nxt_chunk = first_chunk_q;
		nxt_has = first_has_q;
		nxt_seen = chunks_seen_q;
		nxt_apps = applies_seen_q;
		nxt_prev = prev_end_q;
		bm_set = 1'b0;
		fin = 1'b0;
		if (first_error_q == ERR_OK) begin
			unique case (req_s1)
				REQ_CHUNK: begin
					priority if (cnt_full) begin
						nxt_err = ERR_SEQ;
						nxt_chunk = NO_CHUNK;
						nxt_has = 1'b0;
					end else if ((chunks_seen_q != '0) && (prev_end_q > off_s1)) begin
						nxt_err = ERR_OVERLAP;
						nxt_chunk = IDX_W'(chunks_seen_q - CNT_W'(1));
						nxt_has = 1'b1;
					end else if (idx_s1 != IDX_W'(chunks_seen_q)) begin
						nxt_err = ERR_INDEX;
						nxt_chunk = IDX_W'(chunks_seen_q);
						nxt_has = 1'b1;
					end else if (size_s1 == '0) begin
						nxt_err = ERR_EMPTY;
						nxt_chunk = IDX_W'(chunks_seen_q);
						nxt_has = 1'b1;
					end else if (bounds_bad) begin
						nxt_err = ERR_BOUNDS;
						nxt_chunk = IDX_W'(chunks_seen_q);
						nxt_has = 1'b1;
					end else begin
						nxt_prev = end_sum[SIZE_W-1:0];
						nxt_seen = chunks_seen_q + CNT_W'(1);
					end
				end
				REQ_APPLY: begin
					priority if (!cnt_full) begin
						nxt_err = ERR_SEQ;
						nxt_chunk = NO_CHUNK;
						nxt_has = 1'b0;
					end else if (apply_missing) begin
						nxt_err = ERR_MISSING;
						nxt_chunk = idx_s1;
						nxt_has = 1'b1;
					end else if (hit) begin
						nxt_err = ERR_DUP;
						nxt_chunk = idx_s1;
						nxt_has = 1'b1;
					end else begin
						bm_set = 1'b1;
						if (applies_seen_q != CNT_MAX) begin
							nxt_apps = applies_seen_q + CNT_W'(1);
						end
					end
				end
				REQ_FINISH: begin
					priority if (!cnt_full) begin
						nxt_err = ERR_SEQ;
						nxt_chunk = NO_CHUNK;
						nxt_has = 1'b0;
					end else if (applies_seen_q != chunk_count_q) begin
						nxt_err = ERR_MISSING;
						nxt_chunk = NO_CHUNK;
						nxt_has = 1'b0;
					end else begin
						nxt_err = ERR_OK;
					end
				end
				default: begin
					nxt_err = ERR_SEQ;
					nxt_chunk = NO_CHUNK;
					nxt_has = 1'b0;
				end
			endcase
		end
		if (req_s1 == REQ_FINISH) begin
			fin = 1'b1;
			nxt_seen = '0;
			nxt_apps = '0;
			nxt_prev = '0;
		end
	end

	assign bm_wr.en = s1_go && bm_set;
	assign bm_wr.clr = s1_go && fin;
	assign bm_wr.row = idx_s1[BM_COL_W +: BM_ROW_AW];
	assign bm_wr.data = bm_rd_data | (BM_COLS'(1) << idx_s1[BM_COL_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunks_seen_q <= '0;
			applies_seen_q <= '0;
			prev_end_q <= '0;
			first_error_q <= ERR_OK;
			first_chunk_q <= '0;
			first_has_q <= 1'b0;
		end else if (s1_go) begin
			chunks_seen_q <= nxt_seen;
			applies_seen_q <= nxt_apps;
			prev_end_q <= nxt_prev;
			first_error_q <= nxt_err;
			first_chunk_q <= nxt_chunk;
			first_has_q <= nxt_has;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			out_code_q <= nxt_err;
			out_chunk_q <= nxt_chunk;
			out_has_q <= nxt_has;
			out_fin_q <= fin;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.error_code = out_code_q;
	assign out_ch.error_chunk = out_chunk_q;
	assign out_ch.error_chunk_valid = out_has_q;
	assign out_ch.finished = out_fin_q;

	`CTOV_ASSERT_NXT(a_err_sticky, clk, arst_n, first_error_q != ERR_OK, first_error_q == $past(first_error_q), "first error changed")
	`CTOV_ASSERT_NXT(a_fin_clears, clk, arst_n, s1_go && (req_s1 == REQ_FINISH), (chunks_seen_q == '0) && (applies_seen_q == '0) && (prev_end_q == '0), "finish did not clear counts")
	`CTOV_ASSERT_IMP(a_out_no_chunk, clk, arst_n, out_valid_q && ((out_code_q == ERR_OK) || (out_code_q == ERR_SEQ)), !out_has_q, "chunk named without cause")

endmodule
`default_nettype wire

// File: rtl/ctov_bitmap.sv
`default_nettype none
`include "chunk_table_order_validator_core_macros.svh"
module ctov_bitmap (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 rd_en,
	input  wire  [ctov_pkg::BM_ROW_AW-1:0]      rd_row,
	input  ctov_pkg::bm_wr_t                    wr,
	output logic [ctov_pkg::BM_COLS-1:0]        rd_data
);
	import ctov_pkg::*;

	logic [BM_COLS-1:0]   mem [BM_ROWS];
	logic [BM_ROWS-1:0]   row_valid_q;
	logic [BM_COLS-1:0]   rd_data_q;
	logic [BM_ROW_AW-1:0] rd_row_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.row] <= wr.data;
		end
	end

	// A row written in the same cycle it is read returns the new contents.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_row_q <= rd_row;
			if (wr.en && (wr.row == rd_row)) begin
				rd_data_q <= wr.data;
			end else begin
				rd_data_q <= mem[rd_row];
			end
		end
	end

	// Rows not written since the last clear read as all zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
		end else if (wr.clr) begin
			row_valid_q <= '0;
		end else if (wr.en) begin
			row_valid_q[wr.row] <= 1'b1;
		end
	end

	assign rd_data = row_valid_q[rd_row_q] ? rd_data_q : '0;

	`CTOV_ASSERT_NXT(a_clr_empties, clk, arst_n, wr.clr, row_valid_q == '0, "bitmap clear missed")
	`CTOV_ASSERT_NXT(a_wr_marks, clk, arst_n, wr.en && !wr.clr, row_valid_q[$past(wr.row)], "row not marked")
	`CTOV_ASSERT_NXT(a_fwd, clk, arst_n, rd_en && wr.en && (rd_row == wr.row), rd_data_q == $past(wr.data), "bypass failed")

endmodule
`default_nettype wire

// File: tb/sv/tb_ctov_checker.sv
`timescale 1ns / 1ps
module tb_ctov_checker (
	input  wire                          clk,
	input  wire                          arst_n,
	ctov_in_if                           in_ch,
	ctov_out_if                          out_ch,
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire  [ctov_pkg::CFG_AW-1:0]  paddr,
	input  wire  [ctov_pkg::CFG_DW-1:0]  pwdata,
	input  wire                          pready,
	output int                           fails,
	output int                           pending
);
	import ctov_pkg::*;

	typedef struct packed {
		logic [2:0]  code;
		logic [31:0] chunk;
		logic        has;
		logic        fin;
	} verdict_t;

	logic [CNT_W-1:0] cfg_count;
	logic [63:0]      payload_start;
	logic [63:0]      file_size;
	logic [63:0]      max_size;

	logic [CNT_W-1:0] chunks_seen;
	logic [CNT_W-1:0] applies_seen;
	logic [63:0]      prev_end;
	bit               referenced [MAX_CHUNKS];
	err_code_t        first_err;
	logic [31:0]      first_chunk;
	logic             first_has;

	verdict_t verdicts_due [$];
	verdict_t due;

	function automatic void clear_container();
		chunks_seen = '0;
		applies_seen = '0;
		prev_end = '0;
		referenced = '{default: 1'b0};
	endfunction

	function automatic void flag(input err_code_t code, input logic [31:0] chunk, input bit has);
		first_err = code;
		first_chunk = has ? chunk : NO_CHUNK;
		first_has = has;
	endfunction

	function automatic verdict_t judge_word(input logic [1:0] req, input logic [31:0] idx,
		input logic [63:0] size, input logic [63:0] off);
		verdict_t v;
		logic [64:0] end_pos;
		end_pos = {1'b0, off} + {1'b0, size};
		v.fin = (req == REQ_FINISH);
		if (req == REQ_FINISH) begin
			if (first_err == ERR_OK) begin
				if (chunks_seen < cfg_count)
					flag(ERR_SEQ, '0, 1'b0);
				else if (applies_seen != cfg_count)
					flag(ERR_MISSING, '0, 1'b0);
			end
		end else if (first_err == ERR_OK) begin
			if (req == REQ_CHUNK) begin
				if (chunks_seen >= cfg_count)
					flag(ERR_SEQ, '0, 1'b0);
				else if (chunks_seen != '0 && prev_end > off)
					flag(ERR_OVERLAP, 32'(chunks_seen - 1'b1), 1'b1);
				else if (idx != 32'(chunks_seen))
					flag(ERR_INDEX, 32'(chunks_seen), 1'b1);
				else if (size == '0)
					flag(ERR_EMPTY, 32'(chunks_seen), 1'b1);
				else if (size > max_size || off < payload_start ||
					end_pos > {1'b0, file_size})
					flag(ERR_BOUNDS, 32'(chunks_seen), 1'b1);
				else begin
					prev_end = end_pos[63:0];
					chunks_seen = chunks_seen + 1'b1;
				end
			end else if (req == REQ_APPLY) begin
				if (chunks_seen < cfg_count)
					flag(ERR_SEQ, '0, 1'b0);
				else if (idx >= 32'(cfg_count) || idx >= MAX_CHUNKS_IDX)
					flag(ERR_MISSING, idx, 1'b1);
				else if (referenced[idx])
					flag(ERR_DUP, idx, 1'b1);
				else begin
					referenced[idx] = 1'b1;
					if (applies_seen != CNT_MAX)
						applies_seen = applies_seen + 1'b1;
				end
			end else begin
				flag(ERR_SEQ, '0, 1'b0);
			end
		end
		v.code = first_err;
		v.chunk = first_chunk;
		v.has = first_has;
		if (req == REQ_FINISH)
			clear_container();
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_count = '0;
			payload_start = '0;
			file_size = '0;
			max_size = '1;
			clear_container();
			first_err = ERR_OK;
			first_chunk = '0;
			first_has = 1'b0;
			verdicts_due.delete();
			fails = 0;
			pending = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (cfg_reg_t'(paddr[CFG_AW-1:3]))
					REG_CHUNK_COUNT: cfg_count = pwdata[CNT_W-1:0];
					REG_PAYLOAD_START: payload_start = pwdata;
					REG_FILE_SIZE: file_size = pwdata;
					REG_MAX_CHUNK: max_size = pwdata;
					default: ;
				endcase
			end
			if (out_ch.valid && out_ch.ready) begin
				if (verdicts_due.size() == 0) begin
					$error("result word with no expectation waiting");
					fails++;
				end else begin
					due = verdicts_due.pop_front();
					if (out_ch.error_code !== due.code) begin
						$error("error_code expected %0d got %0d", due.code, out_ch.error_code);
						fails++;
					end
					if (out_ch.error_chunk !== due.chunk) begin
						$error("error_chunk expected %0h got %0h", due.chunk, out_ch.error_chunk);
						fails++;
					end
					if (out_ch.error_chunk_valid !== due.has) begin
						$error("error_chunk_valid expected %0d got %0d", due.has,
							out_ch.error_chunk_valid);
						fails++;
					end
					if (out_ch.finished !== due.fin) begin
						$error("finished expected %0d got %0d", due.fin, out_ch.finished);
						fails++;
					end
				end
			end
			if (in_ch.valid && in_ch.ready)
				verdicts_due.push_back(judge_word(in_ch.req_type, in_ch.entry_index,
					in_ch.chunk_size, in_ch.chunk_offset));
			pending = verdicts_due.size();
		end
	end
endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import ctov_pkg::*;

	localparam int RANDOM_ITEMS = 1500;
	localparam int STALL_LIMIT = 5000;
	localparam logic [63:0] ALL_ONES = '1;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]  req;
		logic [31:0] idx;
		logic [63:0] size;
		logic [63:0] off;
	} entry_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [CFG_AW-1:0] paddr;
	logic [CFG_DW-1:0] pwdata;
	logic [CFG_DW-1:0] prdata;
	logic              pready;
	int                fails;
	int                pending;
	int                quiet = 0;
	int                sent = 0;
	bit                calm = 1'b0;
	entry_t            batch [$];
	logic [CNT_W-1:0]  table_len;
	logic [63:0]       pay_start;
	logic [63:0]       file_end;
	logic [63:0]       size_cap;

	ctov_in_if in_ch ();
	ctov_out_if out_ch ();

	chunk_table_order_validator_core u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	tb_ctov_checker u_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.pready  (pready),
		.fails   (fails),
		.pending (pending)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [63:0] pick_upto(input logic [63:0] lim);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return lim;
		if (r < 15)
			return 64'd0;
		if (r < 65)
			return (lim < 64'd16) ? 64'($urandom_range(0, 32'(lim))) : 64'($urandom_range(0, 16));
		if (lim == ALL_ONES)
			return rand64();
		return rand64() % (lim + 64'd1);
	endfunction

	function automatic int pick_pause();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic send_entry(input entry_t w);
		int gap;
		gap = calm ? 0 : pick_pause();
		if (gap > 0) begin
			in_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.req_type = w.req;
		in_ch.entry_index = w.idx;
		in_ch.chunk_size = w.size;
		in_ch.chunk_offset = w.off;
		in_ch.valid = 1'b1;
		do @(posedge clk); while (!in_ch.ready);
		@(negedge clk);
	endtask

	task automatic send_batch();
		foreach (batch[i]) begin
			send_entry(batch[i]);
			sent++;
		end
	endtask

	task automatic settle();
		in_ch.valid = 1'b0;
		wait (pending == 0);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t which, input logic [63:0] value);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {which, 3'b000};
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	initial begin
		int hold;
		hold = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				out_ch.ready = 1'b0;
				hold--;
			end else begin
				out_ch.ready = 1'b1;
				if (!calm)
					hold = pick_pause();
			end
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= STALL_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		entry_t      e;
		int          order [$];
		int          box;
		int          n_chunks;
		int          p;
		int          j;
		int          t;
		int          spoil_at;
		bit          new_cfg;
		bit          spoiled;
		logic [63:0] cursor;
		logic [63:0] room;
		logic [63:0] gap;
		logic [63:0] sz;
		logic [63:0] junk;

		in_ch.valid = 1'b0;
		in_ch.req_type = '0;
		in_ch.entry_index = '0;
		in_ch.chunk_size = '0;
		in_ch.chunk_offset = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		batch = '{entry_t'{REQ_FINISH, 32'hFFFF_FFFF, ALL_ONES, ALL_ONES}};
		send_batch();

		settle();
		write_reg(REG_CHUNK_COUNT, 64'd3);
		write_reg(REG_PAYLOAD_START, ALL_ONES - 64'd300);
		write_reg(REG_FILE_SIZE, ALL_ONES);
		write_reg(REG_MAX_CHUNK, ALL_ONES);
		batch = '{
			entry_t'{REQ_CHUNK, 32'd0, 64'd100, ALL_ONES - 64'd300},
			entry_t'{REQ_CHUNK, 32'd1, 64'd100, ALL_ONES - 64'd200},
			entry_t'{REQ_CHUNK, 32'd2, 64'd100, ALL_ONES - 64'd100},
			entry_t'{REQ_APPLY, 32'd2, 64'd0, 64'd0},
			entry_t'{REQ_APPLY, 32'd0, 64'd0, 64'd0},
			entry_t'{REQ_APPLY, 32'd1, 64'd0, 64'd0},
			entry_t'{REQ_FINISH, 32'd0, 64'd0, 64'd0}
		};
		send_batch();

		settle();
		write_reg(REG_CHUNK_COUNT, 64'd2);
		write_reg(REG_PAYLOAD_START, 64'd0);
		write_reg(REG_FILE_SIZE, 64'd2);
		write_reg(REG_MAX_CHUNK, 64'd1);
		batch = '{
			entry_t'{REQ_CHUNK, 32'd0, 64'd1, 64'd0},
			entry_t'{REQ_CHUNK, 32'd1, 64'd1, 64'd1},
			entry_t'{REQ_APPLY, 32'd1, ALL_ONES, ALL_ONES},
			entry_t'{REQ_APPLY, 32'd0, ALL_ONES, ALL_ONES},
			entry_t'{REQ_FINISH, 32'd0, ALL_ONES, ALL_ONES}
		};
		send_batch();

		// The first error is sticky until reset, so it is held back until late in the run.
		spoiled = 1'b0;
		spoil_at = $urandom_range(1150, 1350);
		for (box = 0; sent < RANDOM_ITEMS; box++) begin
			new_cfg = (box < 2) || ($urandom_range(0, 3) == 0);
			if (new_cfg) begin
				if (box == 0)
					table_len = CNT_W'(MAX_CHUNKS / 2);
				else if (spoiled && $urandom_range(0, 4) == 0)
					table_len = CNT_MAX;
				else if ($urandom_range(0, 9) == 0)
					table_len = CNT_W'($urandom_range(13, 64));
				else
					table_len = CNT_W'($urandom_range(0, 12));
				case ($urandom_range(0, 3))
					0: begin
						pay_start = pick_upto(64'd4096);
						file_end = pay_start + 64'(table_len) + pick_upto(64'd100000);
						size_cap = pick_upto(64'd5000) + 64'd1;
					end
					1: begin
						pay_start = ALL_ONES - 64'(table_len) - pick_upto(64'd1 << 40);
						file_end = ALL_ONES;
						size_cap = ALL_ONES;
					end
					2: begin
						pay_start = pick_upto(ALL_ONES >> 1);
						file_end = pay_start + 64'(table_len) + pick_upto(64'd64);
						size_cap = pick_upto(64'd3) + 64'd1;
					end
					default: begin
						pay_start = rand64() >> $urandom_range(1, 63);
						file_end = pay_start + 64'(table_len) +
							pick_upto(ALL_ONES - pay_start - 64'(table_len));
						size_cap = pick_upto(ALL_ONES - 64'd1) + 64'd1;
					end
				endcase
				settle();
				junk = rand64();
				write_reg(REG_CHUNK_COUNT, {junk[63:CNT_W], table_len});
				write_reg(REG_PAYLOAD_START, pay_start);
				write_reg(REG_FILE_SIZE, file_end);
				write_reg(REG_MAX_CHUNK, size_cap);
			end
			calm = ($urandom_range(0, 4) == 0);
			n_chunks = (box > 0 && table_len > CNT_W'(64)) ? 8 : int'(table_len);

			batch.delete();
			cursor = pay_start;
			for (int i = 0; i < n_chunks; i++) begin
				room = file_end - cursor - 64'(int'(table_len) - i);
				gap = ($urandom_range(0, 2) == 0) ? 64'd0 : pick_upto(room);
				sz = (size_cap - 64'd1 < room - gap) ? size_cap - 64'd1 : room - gap;
				sz = pick_upto(sz) + 64'd1;
				batch.push_back(entry_t'{REQ_CHUNK, 32'(i), sz, cursor + gap});
				cursor = cursor + gap + sz;
			end
			order.delete();
			for (int i = 0; i < n_chunks; i++)
				order.push_back(i);
			for (int i = n_chunks - 1; i > 0; i--) begin
				j = $urandom_range(0, i);
				t = order[i];
				order[i] = order[j];
				order[j] = t;
			end
			foreach (order[i])
				batch.push_back(entry_t'{REQ_APPLY, 32'(order[i]), rand64(), rand64()});
			batch.push_back(entry_t'{REQ_FINISH, $urandom, rand64(), rand64()});

			if (!spoiled && sent >= spoil_at) begin
				p = $urandom_range(0, batch.size() - 1);
				e = batch[p];
				case ($urandom_range(0, 7))
					0: begin
						e.idx = e.idx ^ (32'd1 << $urandom_range(0, 31));
						batch[p] = e;
					end
					1: begin
						e.size = 64'd0;
						batch[p] = e;
					end
					2: begin
						e.size = ALL_ONES - pick_upto(64'd16);
						batch[p] = e;
					end
					3: begin
						e.off = e.off - pick_upto(64'd16) - 64'd1;
						batch[p] = e;
					end
					4: begin
						e.req = REQ_UNUSED;
						batch[p] = e;
					end
					5: batch.delete(p);
					6: batch.insert(p, e);
					default: batch.insert(p, entry_t'{REQ_FINISH, $urandom, rand64(), rand64()});
				endcase
				spoiled = 1'b1;
			end
			if (spoiled) begin
				repeat ($urandom_range(0, 6))
					batch.insert($urandom_range(0, batch.size()), entry_t'{2'($urandom),
						($urandom_range(0, 1) == 1) ? $urandom : 32'($urandom_range(0, 2047)),
						rand64(), rand64()});
			end
			send_batch();
		end

		settle();
		repeat (5) @(negedge clk);
		if (fails == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule

// File: filelist.f
+incdir+rtl
rtl/ctov_pkg.sv
rtl/ctov_if.sv
rtl/ctov_bitmap.sv
rtl/chunk_table_order_validator_core.sv
tb/sv/tb_ctov_checker.sv
tb/sv/tb_top.sv
